// ----- src/rmj_pkg.sv -----
// ----------------------------------------------------------------------------
// rmj_pkg
// Shared types, widths and helpers of the radar measurement Jacobian.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package rmj_pkg;

  localparam int FRAC_BITS_DEF = 16;
  localparam int FIELD_W       = 32;
  localparam int CFG_W         = 33;
  localparam logic [CFG_W-1:0] CFG_RESET = 33'd1;
  localparam int S_W           = 64;
  localparam int R_W           = 32;
  localparam int PROD_W        = 96;
  localparam int QUO_W         = 32;
  localparam int SQRT_REM_W    = 34;
  localparam int SQRT_LAT      = 32;
  localparam int DIV_LAT       = QUO_W + 1;

  typedef struct packed {
    logic signed [FIELD_W-1:0] pos_x;
    logic signed [FIELD_W-1:0] pos_y;
    logic signed [FIELD_W-1:0] vel_x;
    logic signed [FIELD_W-1:0] vel_y;
  } in_t;

  typedef struct packed {
    logic signed [FIELD_W-1:0] d_range_dx;
    logic signed [FIELD_W-1:0] d_range_dy;
    logic signed [FIELD_W-1:0] d_bearing_dx;
    logic signed [FIELD_W-1:0] d_bearing_dy;
    logic signed [FIELD_W-1:0] d_rate_dx;
    logic signed [FIELD_W-1:0] d_rate_dy;
    logic                      saturated;
  } out_t;

  // per-item data that rides along the square-root chain
  typedef struct packed {
    logic              nx;
    logic              ny;
    logic              dneg;
    logic              dmag_nz;
    logic [31:0]       ax;
    logic [31:0]       ay;
    logic [S_W-1:0]    s;
    logic [PROD_W-1:0] pay;
    logic [PROD_W-1:0] pax;
  } band_t;

  // sign information that rides along the divider chains
  typedef struct packed {
    logic nx;
    logic ny;
    logic ay_nz;
    logic dneg;
    logic dmag_nz;
  } flag_t;

  typedef struct packed {
    logic [FIELD_W-1:0] val;
    logic               sat;
  } clip_t;

  // apply sign to a truncated magnitude and clip to the signed 32-bit range
  function automatic clip_t clip_q(logic [QUO_W-1:0] q, logic ovf, logic neg);
    clip_t c;
    if (neg) begin
      if (ovf || (q > 32'h8000_0000)) begin
        c.val = 32'h8000_0000;
        c.sat = 1'b1;
      end else begin
        c.val = ~q + 32'd1;
        c.sat = 1'b0;
      end
    end else begin
      if (ovf || q[QUO_W-1]) begin
        c.val = 32'h7fff_ffff;
        c.sat = 1'b1;
      end else begin
        c.val = q;
        c.sat = 1'b0;
      end
    end
    return c;
  endfunction

endpackage

`default_nettype wire

// ----- src/rmj_sqrt_cell.sv -----
// ----------------------------------------------------------------------------
// rmj_sqrt_cell
// One step of the digit-by-digit square root: two radicand bits, one root bit.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module rmj_sqrt_cell (
  input  wire logic                              clk_i,
  input  wire logic                              en_i,
  input  wire logic [rmj_pkg::SQRT_REM_W-1:0]    rem_i,
  input  wire logic [rmj_pkg::R_W-1:0]           root_i,
  input  wire logic [rmj_pkg::S_W-1:0]           rad_i,
  output logic      [rmj_pkg::SQRT_REM_W-1:0]    rem_o,
  output logic      [rmj_pkg::R_W-1:0]           root_o,
  output logic      [rmj_pkg::S_W-1:0]           rad_o
);

  localparam int CUR_W = rmj_pkg::SQRT_REM_W + 2;

  logic [CUR_W-1:0] cur;
  logic [CUR_W-1:0] trial;
  logic [CUR_W-1:0] diff;
  logic             ge;

  assign cur   = {rem_i, rad_i[rmj_pkg::S_W-1 -: 2]};
  assign trial = CUR_W'({root_i, 2'b01});
  assign ge    = (cur >= trial);
  assign diff  = cur - trial;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      rem_o  <= ge ? diff[rmj_pkg::SQRT_REM_W-1:0] : cur[rmj_pkg::SQRT_REM_W-1:0];
      root_o <= {root_i[rmj_pkg::R_W-2:0], ge};
      rad_o  <= {rad_i[rmj_pkg::S_W-3:0], 2'b00};
    end
  end

endmodule

`default_nettype wire

// ----- src/rmj_sqrt.sv -----
// ----------------------------------------------------------------------------
// rmj_sqrt
// Row of square-root cells giving the floor root of a 64-bit value.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module rmj_sqrt (
  input  wire logic                       clk_i,
  input  wire logic                       en_i,
  input  wire logic [rmj_pkg::S_W-1:0]    rad_i,
  output logic      [rmj_pkg::R_W-1:0]    root_o
);

  localparam int N = rmj_pkg::SQRT_LAT;

  logic [rmj_pkg::SQRT_REM_W-1:0] rem  [N+1];
  logic [rmj_pkg::R_W-1:0]        root [N+1];
  logic [rmj_pkg::S_W-1:0]        rad  [N+1];

  assign rem[0]  = '0;
  assign root[0] = '0;
  assign rad[0]  = rad_i;

  for (genvar k = 0; k < N; k++) begin : g_cell
    rmj_sqrt_cell u_cell (
      .clk_i  (clk_i),
      .en_i   (en_i),
      .rem_i  (rem[k]),
      .root_i (root[k]),
      .rad_i  (rad[k]),
      .rem_o  (rem[k+1]),
      .root_o (root[k+1]),
      .rad_o  (rad[k+1])
    );
  end

  assign root_o = root[N];

endmodule

`default_nettype wire

// ----- src/rmj_div_cell.sv -----
// ----------------------------------------------------------------------------
// rmj_div_cell
// One restoring division step: shifts in a numerator bit, yields a quotient bit.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module rmj_div_cell #(
  parameter int DEN_W = 32
) (
  input  wire logic                       clk_i,
  input  wire logic                       en_i,
  input  wire logic [DEN_W-1:0]           rem_i,
  input  wire logic [DEN_W-1:0]           den_i,
  input  wire logic [rmj_pkg::QUO_W-1:0]  bits_i,
  input  wire logic [rmj_pkg::QUO_W-1:0]  q_i,
  input  wire logic                       ovf_i,
  output logic      [DEN_W-1:0]           rem_o,
  output logic      [DEN_W-1:0]           den_o,
  output logic      [rmj_pkg::QUO_W-1:0]  bits_o,
  output logic      [rmj_pkg::QUO_W-1:0]  q_o,
  output logic                            ovf_o
);

  logic [DEN_W:0] trial;
  logic [DEN_W:0] diff;
  logic           ge;

  assign trial = {rem_i, bits_i[rmj_pkg::QUO_W-1]};
  assign ge    = (trial >= {1'b0, den_i});
  assign diff  = trial - {1'b0, den_i};

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      rem_o  <= ge ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
      den_o  <= den_i;
      bits_o <= {bits_i[rmj_pkg::QUO_W-2:0], 1'b0};
      q_o    <= {q_i[rmj_pkg::QUO_W-2:0], ge};
      ovf_o  <= ovf_i;
    end
  end

endmodule

`default_nettype wire

// ----- src/rmj_div.sv -----
// ----------------------------------------------------------------------------
// rmj_div
// Truncating divider: overflow check stage, then a row of division cells.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module rmj_div #(
  parameter int NUM_W = 48,
  parameter int DEN_W = 32
) (
  input  wire logic                       clk_i,
  input  wire logic                       en_i,
  input  wire logic [NUM_W-1:0]           num_i,
  input  wire logic [DEN_W-1:0]           den_i,
  output logic      [rmj_pkg::QUO_W-1:0]  q_o,
  output logic                            ovf_o
);

  localparam int N    = rmj_pkg::QUO_W;
  localparam int HI_W = NUM_W - N;

  logic [DEN_W-1:0] hi_ext;
  logic [DEN_W-1:0] rem  [N+1];
  logic [DEN_W-1:0] den  [N+1];
  logic [N-1:0]     bits [N+1];
  logic [N-1:0]     q    [N+1];
  logic             ovf  [N+1];

  assign hi_ext = DEN_W'(num_i[NUM_W-1 -: HI_W]);

  // quotient of 2^32 or more only needs to be flagged
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      rem[0]  <= hi_ext;
      den[0]  <= den_i;
      bits[0] <= num_i[N-1:0];
      q[0]    <= '0;
      ovf[0]  <= (hi_ext >= den_i);
    end
  end

  for (genvar k = 0; k < N; k++) begin : g_cell
    rmj_div_cell #(.DEN_W(DEN_W)) u_cell (
      .clk_i  (clk_i),
      .en_i   (en_i),
      .rem_i  (rem[k]),
      .den_i  (den[k]),
      .bits_i (bits[k]),
      .q_i    (q[k]),
      .ovf_i  (ovf[k]),
      .rem_o  (rem[k+1]),
      .den_o  (den[k+1]),
      .bits_o (bits[k+1]),
      .q_o    (q[k+1]),
      .ovf_o  (ovf[k+1])
    );
  end

  assign q_o   = q[N];
  assign ovf_o = ovf[N];

endmodule

`default_nettype wire

// ----- src/radar_measurement_jacobian.sv -----
// ----------------------------------------------------------------------------
// radar_measurement_jacobian
// Radar range, bearing and range-rate Jacobian of a Cartesian state.
// ----------------------------------------------------------------------------
// Takes one state per cycle unless a held result stalls the output, and
// returns the six distinct nonzero Jacobian entries plus a saturation flag,
// one result per state, in order. The block is a fixed pipeline: three front
// stages form the squares, the floored s and the cross term, a row of 32
// square-root cells produces r while the numerators are formed alongside,
// two stages form s*r, and six rows of 32 division cells (plus one overflow
// check stage each) give the quotients. Each cell row takes one step per
// cycle, so a new state can enter before earlier ones finish. The whole
// pipeline holds only while a result waits on a stalled output. The floor
// register is written through its own port and should only change while no
// item is in flight.
`timescale 1ns / 1ps
`default_nettype none

module radar_measurement_jacobian #(
  parameter int FRAC_BITS = rmj_pkg::FRAC_BITS_DEF
) (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  // floor register write
  input  wire logic                        cfg_valid_i,
  output logic                             cfg_ready_o,
  input  wire logic [rmj_pkg::CFG_W-1:0]   cfg_data_i,
  // state in
  input  wire logic                        in_valid_i,
  output logic                             in_stall_o,
  input  wire rmj_pkg::in_t                in_data_i,
  // jacobian out
  output logic                             out_valid_o,
  input  wire logic                        out_stall_i,
  output rmj_pkg::out_t                    out_data_o
);

  localparam int S_W      = rmj_pkg::S_W;
  localparam int R_W      = rmj_pkg::R_W;
  localparam int PROD_W   = rmj_pkg::PROD_W;
  localparam int TWO_F    = 2 * FRAC_BITS;
  localparam int UP_SH    = (TWO_F >= 32) ? TWO_F - 32 : 0;
  localparam int DN_SH    = (TWO_F < 32) ? 32 - TWO_F : 0;
  localparam int BAND_DLY = rmj_pkg::SQRT_LAT - 2;
  localparam int FL_DLY   = rmj_pkg::DIV_LAT;
  localparam int LAT      = 3 + 2 + BAND_DLY + 2 + FL_DLY;

  // global advance: everything moves unless a finished result is held
  logic en;
  logic out_valid_q;

  assign en          = !(out_valid_q && out_stall_i);
  assign in_stall_o  = !en;
  assign cfg_ready_o = 1'b1;

  // floor register and its conversion to the fraction of s
  logic [rmj_pkg::CFG_W-1:0] cfg_q;
  logic [S_W-1:0]            cfg_ext;
  logic [S_W-1:0]            floor_raw;
  logic [S_W-1:0]            floor_s;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= rmj_pkg::CFG_RESET;
    end else if (cfg_valid_i) begin
      cfg_q <= cfg_data_i;
    end
  end

  assign cfg_ext = S_W'(cfg_q);

  // right shift rounds up so a nonzero floor stays nonzero
  always_comb begin
    if (TWO_F >= 32) begin
      floor_raw = cfg_ext << UP_SH;
    end else begin
      floor_raw = (cfg_ext + ((S_W'(1) << DN_SH) - S_W'(1))) >> DN_SH;
    end
  end

  // a zero floor acts as one lsb
  assign floor_s = (floor_raw == '0) ? S_W'(1) : floor_raw;

  // valid bits for every pipeline position
  logic [LAT-1:0] vld_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q       <= '0;
      out_valid_q <= 1'b0;
    end else if (en) begin
      vld_q       <= {vld_q[LAT-2:0], in_valid_i};
      out_valid_q <= vld_q[LAT-1];
    end
  end

  // stage 1: squares, cross products, magnitudes
  logic signed [31:0] x, y, vx, vy;
  logic signed [63:0] xx_d, yy_d, p1_d, p2_d;
  logic        [31:0] ax_d, ay_d;

  assign x  = in_data_i.pos_x;
  assign y  = in_data_i.pos_y;
  assign vx = in_data_i.vel_x;
  assign vy = in_data_i.vel_y;

  assign xx_d = x * x;
  assign yy_d = y * y;
  assign p1_d = vx * y;
  assign p2_d = vy * x;
  assign ax_d = x[31] ? (~x + 32'd1) : x;
  assign ay_d = y[31] ? (~y + 32'd1) : y;

  logic        [63:0] s1_xx_q, s1_yy_q;
  logic signed [63:0] s1_p1_q, s1_p2_q;
  logic        [31:0] s1_ax_q, s1_ay_q;
  logic               s1_nx_q, s1_ny_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      s1_xx_q <= xx_d;
      s1_yy_q <= yy_d;
      s1_p1_q <= p1_d;
      s1_p2_q <= p2_d;
      s1_ax_q <= ax_d;
      s1_ay_q <= ay_d;
      s1_nx_q <= x[31];
      s1_ny_q <= y[31];
    end
  end

  // stage 2: s and both orders of the cross-term difference
  logic [S_W-1:0] s2_s_q;
  logic [63:0]    s2_dpos_q, s2_dmin_q;
  logic           s2_dneg_q;
  logic [31:0]    s2_ax_q, s2_ay_q;
  logic           s2_nx_q, s2_ny_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      s2_s_q    <= s1_xx_q + s1_yy_q;
      s2_dpos_q <= 64'(s1_p1_q - s1_p2_q);
      s2_dmin_q <= 64'(s1_p2_q - s1_p1_q);
      s2_dneg_q <= (s1_p1_q < s1_p2_q);
      s2_ax_q   <= s1_ax_q;
      s2_ay_q   <= s1_ay_q;
      s2_nx_q   <= s1_nx_q;
      s2_ny_q   <= s1_ny_q;
    end
  end

  // stage 3: floored s and magnitude of the difference
  logic [S_W-1:0] s3_sf_q;
  logic [63:0]    s3_dmag_q;
  logic           s3_dneg_q;
  logic [31:0]    s3_ax_q, s3_ay_q;
  logic           s3_nx_q, s3_ny_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      s3_sf_q   <= (s2_s_q < floor_s) ? floor_s : s2_s_q;
      s3_dmag_q <= s2_dneg_q ? s2_dmin_q : s2_dpos_q;
      s3_dneg_q <= s2_dneg_q;
      s3_ax_q   <= s2_ax_q;
      s3_ay_q   <= s2_ay_q;
      s3_nx_q   <= s2_nx_q;
      s3_ny_q   <= s2_ny_q;
    end
  end

  // square-root cell row, fed by the floored s
  logic [R_W-1:0] root;

  rmj_sqrt u_sqrt (
    .clk_i  (clk_i),
    .en_i   (en),
    .rad_i  (s3_sf_q),
    .root_o (root)
  );

  // stage 4: partial products of the numerators
  rmj_pkg::band_t s4_q;
  logic [63:0]    s4_ay_lo_q, s4_ay_hi_q, s4_ax_lo_q, s4_ax_hi_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      s4_q.nx      <= s3_nx_q;
      s4_q.ny      <= s3_ny_q;
      s4_q.dneg    <= s3_dneg_q;
      s4_q.dmag_nz <= (s3_dmag_q != '0);
      s4_q.ax      <= s3_ax_q;
      s4_q.ay      <= s3_ay_q;
      s4_q.s       <= s3_sf_q;
      s4_q.pay     <= '0;
      s4_q.pax     <= '0;
      s4_ay_lo_q   <= s3_ay_q * s3_dmag_q[31:0];
      s4_ay_hi_q   <= s3_ay_q * s3_dmag_q[63:32];
      s4_ax_lo_q   <= s3_ax_q * s3_dmag_q[31:0];
      s4_ax_hi_q   <= s3_ax_q * s3_dmag_q[63:32];
    end
  end

  // stage 5: numerators |y|*dmag and |x|*dmag
  rmj_pkg::band_t s5_d;

  always_comb begin
    s5_d     = s4_q;
    s5_d.pay = {s4_ay_hi_q, 32'd0} + PROD_W'(s4_ay_lo_q);
    s5_d.pax = {s4_ax_hi_q, 32'd0} + PROD_W'(s4_ax_lo_q);
  end

  // band delay line: stage 5 output and the rest of the root latency
  rmj_pkg::band_t band_q [BAND_DLY+1];

  always_ff @(posedge clk_i) begin
    if (en) begin
      band_q[0] <= s5_d;
      for (int i = 1; i <= BAND_DLY; i++) begin
        band_q[i] <= band_q[i-1];
      end
    end
  end

  // stage 6: partial products of s*r
  rmj_pkg::band_t s6_q;
  logic [R_W-1:0] s6_r_q;
  logic [63:0]    s6_lo_q, s6_hi_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      s6_q    <= band_q[BAND_DLY];
      s6_r_q  <= root;
      s6_lo_q <= band_q[BAND_DLY].s[31:0] * root;
      s6_hi_q <= band_q[BAND_DLY].s[63:32] * root;
    end
  end

  // stage 7: s*r
  rmj_pkg::band_t  s7_q;
  logic [R_W-1:0]  s7_r_q;
  logic [PROD_W-1:0] s7_sr_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      s7_q    <= s6_q;
      s7_r_q  <= s6_r_q;
      s7_sr_q <= {s6_hi_q, 32'd0} + PROD_W'(s6_lo_q);
    end
  end

  // division cell rows, all six in lockstep
  localparam int NA_W = 32 + FRAC_BITS;
  localparam int NB_W = 32 + TWO_F;
  localparam int NC_W = PROD_W + FRAC_BITS;

  logic [rmj_pkg::QUO_W-1:0] q_rx, q_ry, q_sy, q_sx, q_py, q_px;
  logic                      o_rx, o_ry, o_sy, o_sx, o_py, o_px;

  rmj_div #(.NUM_W(NA_W), .DEN_W(R_W)) u_div_rx (
    .clk_i (clk_i), .en_i (en),
    .num_i ({s7_q.ax, FRAC_BITS'(0)}), .den_i (s7_r_q),
    .q_o   (q_rx), .ovf_o (o_rx)
  );

  rmj_div #(.NUM_W(NA_W), .DEN_W(R_W)) u_div_ry (
    .clk_i (clk_i), .en_i (en),
    .num_i ({s7_q.ay, FRAC_BITS'(0)}), .den_i (s7_r_q),
    .q_o   (q_ry), .ovf_o (o_ry)
  );

  rmj_div #(.NUM_W(NB_W), .DEN_W(S_W)) u_div_sy (
    .clk_i (clk_i), .en_i (en),
    .num_i ({s7_q.ay, TWO_F'(0)}), .den_i (s7_q.s),
    .q_o   (q_sy), .ovf_o (o_sy)
  );

  rmj_div #(.NUM_W(NB_W), .DEN_W(S_W)) u_div_sx (
    .clk_i (clk_i), .en_i (en),
    .num_i ({s7_q.ax, TWO_F'(0)}), .den_i (s7_q.s),
    .q_o   (q_sx), .ovf_o (o_sx)
  );

  rmj_div #(.NUM_W(NC_W), .DEN_W(PROD_W)) u_div_py (
    .clk_i (clk_i), .en_i (en),
    .num_i ({s7_q.pay, FRAC_BITS'(0)}), .den_i (s7_sr_q),
    .q_o   (q_py), .ovf_o (o_py)
  );

  rmj_div #(.NUM_W(NC_W), .DEN_W(PROD_W)) u_div_px (
    .clk_i (clk_i), .en_i (en),
    .num_i ({s7_q.pax, FRAC_BITS'(0)}), .den_i (s7_sr_q),
    .q_o   (q_px), .ovf_o (o_px)
  );

  // sign flags follow the division rows
  rmj_pkg::flag_t fl_d;
  rmj_pkg::flag_t fl_q [FL_DLY];

  assign fl_d.nx      = s7_q.nx;
  assign fl_d.ny      = s7_q.ny;
  assign fl_d.ay_nz   = (s7_q.ay != '0);
  assign fl_d.dneg    = s7_q.dneg;
  assign fl_d.dmag_nz = s7_q.dmag_nz;

  always_ff @(posedge clk_i) begin
    if (en) begin
      fl_q[0] <= fl_d;
      for (int i = 1; i < FL_DLY; i++) begin
        fl_q[i] <= fl_q[i-1];
      end
    end
  end

  // sign, clip and collect the saturation flag
  rmj_pkg::flag_t fl;
  rmj_pkg::clip_t c_rx, c_ry, c_sy, c_sx, c_py, c_px;
  rmj_pkg::out_t  out_d;
  rmj_pkg::out_t  out_q;

  assign fl = fl_q[FL_DLY-1];

  assign c_rx = rmj_pkg::clip_q(q_rx, o_rx, fl.nx);
  assign c_ry = rmj_pkg::clip_q(q_ry, o_ry, fl.ny);
  assign c_sy = rmj_pkg::clip_q(q_sy, o_sy, !fl.ny && fl.ay_nz);
  assign c_sx = rmj_pkg::clip_q(q_sx, o_sx, fl.nx);
  assign c_py = rmj_pkg::clip_q(q_py, o_py, fl.ny ^ fl.dneg);
  assign c_px = rmj_pkg::clip_q(q_px, o_px, (fl.nx ^ !fl.dneg) && fl.dmag_nz);

  always_comb begin
    out_d.d_range_dx   = c_rx.val;
    out_d.d_range_dy   = c_ry.val;
    out_d.d_bearing_dx = c_sy.val;
    out_d.d_bearing_dy = c_sx.val;
    out_d.d_rate_dx    = c_py.val;
    out_d.d_rate_dy    = c_px.val;
    out_d.saturated    = c_rx.sat | c_ry.sat | c_sy.sat | c_sx.sat | c_py.sat | c_px.sat;
  end

  // output register, held while the result transfer is stalled
  always_ff @(posedge clk_i) begin
    if (en) begin
      out_q <= out_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

`default_nettype wire

// ----- sim/radar_measurement_jacobian_tb.sv -----
// ----------------------------------------------------------------------------
// radar_measurement_jacobian_tb
// Self-checking bench for the radar measurement Jacobian.
// ----------------------------------------------------------------------------
// Drives Cartesian states through the block under several range floors,
// predicts each Jacobian with exact wide integer arithmetic, and compares
// every output transfer field by field against the oldest prediction.
// Both channels idle at random, the receiver holds off for a long stretch
// once to fill the pipeline, and the sender pauses once until it drains.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module radar_measurement_jacobian_tb;

  localparam int  PIPE_LAT    = 70;
  localparam int  MAX_WAIT    = 18;
  localparam int  LONG_HOLD   = 300;
  localparam int  CYCLE_LIMIT = 600000;

  logic                         clk;
  logic                         rst_n;
  logic                         cfg_valid;
  logic                         cfg_ready;
  logic [rmj_pkg::CFG_W-1:0]    cfg_data;
  logic                         in_valid;
  logic                         in_stall;
  rmj_pkg::in_t                 in_data;
  logic                         out_valid;
  logic                         out_stall;
  rmj_pkg::out_t                out_data;

  // bench copy of the floor register
  logic [rmj_pkg::CFG_W-1:0]    floor_reg;
  rmj_pkg::out_t                expected_jacobians[$];
  int unsigned                  error_count;
  int unsigned                  cycle_count;
  // receiver control: long hold-off request and a stretch with no idling
  logic                         hold_request;
  logic                         no_idle;

  radar_measurement_jacobian u_top (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .cfg_valid_i (cfg_valid),
    .cfg_ready_o (cfg_ready),
    .cfg_data_i  (cfg_data),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .in_data_i   (in_data),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .out_data_o  (out_data)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // --------------------------------------------------------------------------
  // predictor
  // --------------------------------------------------------------------------

  function automatic logic [63:0] floor_sqrt(logic [63:0] v);
    logic [63:0] res;
    logic [63:0] bitv;
    res  = '0;
    bitv = 64'd1 << 62;
    while (bitv > v) bitv = bitv >> 2;
    while (bitv != 0) begin
      if (v >= res + bitv) begin
        v   = v - (res + bitv);
        res = (res >> 1) + bitv;
      end else begin
        res = res >> 1;
      end
      bitv = bitv >> 2;
    end
    return res;
  endfunction

  // truncated quotient, capped at 2^32 which is enough to see clipping
  function automatic logic [63:0] capped_quot(logic [127:0] num, logic [127:0] den);
    logic [127:0] q;
    if (den == 0) return 64'd1 << 32;
    q = num / den;
    if (q > (128'd1 << 32)) return 64'd1 << 32;
    return q[63:0];
  endfunction

  // sign a magnitude and clip into the signed 32-bit range
  function automatic logic [31:0] signed_clip(logic [63:0] mag, logic neg, inout logic sat);
    logic [63:0] t;
    if (neg) begin
      if (mag > 64'h8000_0000) begin
        mag = 64'h8000_0000;
        sat = 1'b1;
      end
      t = (64'h1_0000_0000 - mag);
      return t[31:0];
    end
    if (mag > 64'h7fff_ffff) begin
      mag = 64'h7fff_ffff;
      sat = 1'b1;
    end
    return mag[31:0];
  endfunction

  function automatic rmj_pkg::out_t jacobian_of(rmj_pkg::in_t st,
                                                logic [rmj_pkg::CFG_W-1:0] floor_val);
    rmj_pkg::out_t      o;
    logic signed [63:0] x, y, vx, vy, p1, p2;
    logic [63:0]        ax, ay, floor_s, s, r, dmag;
    logic [127:0]       sr, num;
    logic               nx, ny, dneg, sat;
    x  = st.pos_x;
    y  = st.pos_y;
    vx = st.vel_x;
    vy = st.vel_y;
    nx = x < 0;
    ny = y < 0;
    ax = nx ? -x : x;
    ay = ny ? -y : y;
    sat = 1'b0;
    // s carries 32 fractional bits, same as the register, so no shift
    floor_s = {31'd0, floor_val};
    if (floor_s == 0) floor_s = 64'd1;
    s = ax * ax + ay * ay;
    if (s < floor_s) s = floor_s;
    r  = floor_sqrt(s);
    sr = {64'd0, s} * {64'd0, r};
    o.d_range_dx   = signed_clip(capped_quot({64'd0, ax} << 16, {64'd0, r}), nx, sat);
    o.d_range_dy   = signed_clip(capped_quot({64'd0, ay} << 16, {64'd0, r}), ny, sat);
    o.d_bearing_dx = signed_clip(capped_quot({64'd0, ay} << 32, {64'd0, s}),
                                 !ny && ay != 0, sat);
    o.d_bearing_dy = signed_clip(capped_quot({64'd0, ax} << 32, {64'd0, s}), nx, sat);
    // cross term kept as sign and magnitude
    p1 = vx * y;
    p2 = vy * x;
    if (p1 >= p2) begin
      dmag = p1 - p2;
      dneg = 1'b0;
    end else begin
      dmag = p2 - p1;
      dneg = 1'b1;
    end
    num = ({64'd0, ay} * {64'd0, dmag}) << 16;
    o.d_rate_dx = signed_clip(capped_quot(num, sr), ny != dneg, sat);
    num = ({64'd0, ax} * {64'd0, dmag}) << 16;
    o.d_rate_dy = signed_clip(capped_quot(num, sr), (nx != !dneg) && dmag != 0, sat);
    o.saturated = sat;
    return o;
  endfunction

  // --------------------------------------------------------------------------
  // checker
  // --------------------------------------------------------------------------

  task automatic compare_field(string name, logic [31:0] exp_v, logic [31:0] act_v);
    if (exp_v !== act_v) begin
      $error("%s mismatch: expected %h, actual %h", name, exp_v, act_v);
      error_count++;
    end
  endtask

  always @(posedge clk) begin
    rmj_pkg::out_t exp_o;
    if (rst_n && out_valid && !out_stall) begin
      if (expected_jacobians.size() == 0) begin
        $error("unexpected output transfer %h", out_data);
        error_count++;
      end else begin
        exp_o = expected_jacobians.pop_front();
        compare_field("d_range_dx", exp_o.d_range_dx, out_data.d_range_dx);
        compare_field("d_range_dy", exp_o.d_range_dy, out_data.d_range_dy);
        compare_field("d_bearing_dx", exp_o.d_bearing_dx, out_data.d_bearing_dx);
        compare_field("d_bearing_dy", exp_o.d_bearing_dy, out_data.d_bearing_dy);
        compare_field("d_rate_dx", exp_o.d_rate_dx, out_data.d_rate_dx);
        compare_field("d_rate_dy", exp_o.d_rate_dy, out_data.d_rate_dy);
        compare_field("saturated", {31'd0, exp_o.saturated}, {31'd0, out_data.saturated});
      end
    end
  end

  // run guard
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("radar_measurement_jacobian_tb: FAIL");
      $finish;
    end
  end

  // --------------------------------------------------------------------------
  // receiver: random stall per result, plus one long counted hold-off
  // --------------------------------------------------------------------------

  initial begin
    int n;
    out_stall = 1'b0;
    @(posedge rst_n);
    forever begin
      @(negedge clk);
      if (hold_request) begin
        out_stall = 1'b1;
        repeat (LONG_HOLD) @(negedge clk);
        hold_request = 1'b0;
      end
      n = no_idle ? 0 : $urandom_range(MAX_WAIT, 0);
      if (n > 0) begin
        out_stall = 1'b1;
        repeat (n - 1) @(negedge clk);
        @(negedge clk);
      end
      out_stall = 1'b0;
      // hold the window open until one transfer happens
      @(posedge clk);
      while (!out_valid) @(posedge clk);
    end
  end

  // --------------------------------------------------------------------------
  // sender and register port
  // --------------------------------------------------------------------------

  // offer one state; valid stays high into the next item when there is no gap
  task automatic send_state(rmj_pkg::in_t st, bit zero_gap = 1'b0);
    int gap;
    gap = (zero_gap || no_idle) ? 0 : $urandom_range(MAX_WAIT, 0);
    if (gap > 0) begin
      in_valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid = 1'b1;
    in_data  = st;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    expected_jacobians.push_back(jacobian_of(st, floor_reg));
    @(negedge clk);
  endtask

  // drop valid right away so the last state is not offered a second time
  task automatic wait_drained();
    in_valid = 1'b0;
    @(negedge clk);
    while (expected_jacobians.size() != 0) @(negedge clk);
    repeat (PIPE_LAT + 10) @(negedge clk);
  endtask

  task automatic write_floor(logic [rmj_pkg::CFG_W-1:0] value);
    wait_drained();
    cfg_valid = 1'b1;
    cfg_data  = value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    floor_reg = value;
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  function automatic rmj_pkg::in_t make_state(int x, int y, int vx, int vy);
    rmj_pkg::in_t st;
    st.pos_x = x;
    st.pos_y = y;
    st.vel_x = vx;
    st.vel_y = vy;
    return st;
  endfunction

  // half full-range fields, a quarter near the origin, a quarter moderate
  function automatic logic [31:0] random_field();
    case ($urandom_range(3, 0))
      0:       return $urandom_range(64, 0) - 32;
      1:       return $signed($urandom_range(32'h0020_0000, 0)) - 32'sh0010_0000;
      default: return $urandom;
    endcase
  endfunction

  function automatic rmj_pkg::in_t random_state();
    return make_state(random_field(), random_field(), random_field(), random_field());
  endfunction

  // --------------------------------------------------------------------------
  // tests
  // --------------------------------------------------------------------------

  task automatic test_directed();
    int lo, hi;
    lo = 32'h8000_0000;
    hi = 32'h7fff_ffff;
    send_state(make_state(0, 0, 0, 0));              // origin, floor takes over
    send_state(make_state(0, 0, hi, lo));
    send_state(make_state(hi, hi, hi, hi));
    send_state(make_state(lo, lo, lo, lo));
    send_state(make_state(hi, lo, lo, hi));
    send_state(make_state(lo, hi, hi, lo));
    send_state(make_state(32'h0001_0000, 0, 0, 32'h0001_0000));  // on x axis
    send_state(make_state(0, 32'h0001_0000, 32'h0001_0000, 0));  // on y axis
    send_state(make_state(-32'sh0001_0000, 0, 0, 0));   // negative x, zero cross term
    send_state(make_state(0, -32'sh0001_0000, 0, 0));   // negative y, zero bearing sign
    send_state(make_state(1, 0, 0, 0));
    send_state(make_state(0, -1, 5, 5));
    send_state(make_state(-1, -1, lo, hi));
    send_state(make_state(1, 1, hi, hi));
    send_state(make_state(32'h0003_0000, 32'h0004_0000, 32'h0002_0000, -32'sh0001_0000));
    send_state(make_state(-32'sh0003_0000, 32'h0004_0000, 7, 7));  // vx*y and vy*x of opposite sign
    send_state(make_state(32'h0000_0100, -32'sh0000_0200, hi, lo));
    send_state(make_state(32'hffff_ffff, 32'h0000_0001, 32'h5555_5555, 32'haaaa_aaaa));
  endtask

  task automatic test_floor_settings();
    logic [rmj_pkg::CFG_W-1:0] floors[5];
    floors[0] = '0;                       // zero acts as one lsb
    floors[1] = 33'h1_0000_0000;          // top register bit only, 1 m^2
    floors[2] = '1;                       // all register bits set
    floors[3] = {1'b0, $urandom};
    floors[4] = 33'd1;
    foreach (floors[i]) begin
      write_floor(floors[i]);
      repeat (6) send_state(make_state(0, 0, $urandom, $urandom));
      repeat (8) send_state(make_state($urandom_range(1024, 0) - 512,
                                       $urandom_range(1024, 0) - 512, $urandom, $urandom));
      repeat (6) send_state(random_state());
    end
  endtask

  task automatic test_random(int count);
    repeat (count) begin
      // an occasional burst with no idling on either side
      if ($urandom_range(40, 0) == 0) no_idle = ~no_idle;
      send_state(random_state());
    end
    no_idle = 1'b0;
  endtask

  task automatic test_backpressure();
    hold_request = 1'b1;
    repeat (150) send_state(random_state(), 1'b1);
  endtask

  task automatic test_drain_pause();
    repeat (20) send_state(random_state());
    wait_drained();
    repeat (20) send_state(random_state());
  endtask

  initial begin
    rst_n        = 1'b0;
    cfg_valid    = 1'b0;
    cfg_data     = '0;
    in_valid     = 1'b0;
    in_data      = '0;
    floor_reg    = rmj_pkg::CFG_RESET;
    error_count  = 0;
    cycle_count  = 0;
    hold_request = 1'b0;
    no_idle      = 1'b0;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    test_directed();
    test_floor_settings();
    test_random(200);
    test_backpressure();
    test_drain_pause();
    write_floor({1'b0, $urandom});
    test_random(80);
    write_floor(33'd1);
    test_random(50);

    wait_drained();
    if (error_count == 0 && expected_jacobians.size() == 0) begin
      $display("radar_measurement_jacobian_tb: PASS");
    end else begin
      $display("radar_measurement_jacobian_tb: FAIL");
    end
    $finish;
  end

endmodule
